@@ sv/tsgd_pkg.sv @@
// tsgd_pkg: shared types, register indexes and reset values for the touch slider
// gesture detector
// no dependencies
package tsgd_pkg;

   localparam int CFG_WIDTH   = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int THR_WIDTH   = 8;
   localparam int SPEED_WIDTH = 8;
   localparam int DIV_NUM_W   = 16;
   localparam int DIV_DEN_W   = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_THRESHOLD    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASELINE_UP        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASELINE_DOWN      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DOWN_DETECT_COUNT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_DETECT_COUNT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SLIDE_COUNT_MIN    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SLIDE_COUNT_MAX    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SLIDE_SPEED_MAX    = 3'd7;

   localparam logic [CFG_WIDTH-1:0] RST_NOISE_THRESHOLD    = 16'd64;
   localparam logic [CFG_WIDTH-1:0] RST_BASELINE           = 16'd0;
   localparam logic [THR_WIDTH-1:0] RST_DOWN_DETECT_COUNT  = 8'd2;
   localparam logic [THR_WIDTH-1:0] RST_PRESS_DETECT_COUNT = 8'd20;
   localparam logic [THR_WIDTH-1:0] RST_SLIDE_COUNT_MIN    = 8'd0;
   localparam logic [THR_WIDTH-1:0] RST_SLIDE_COUNT_MAX    = 8'd10;
   localparam logic [THR_WIDTH-1:0] RST_SLIDE_SPEED_MAX    = 8'd255;

   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_UP    = 2'd1,
      EV_DOWN  = 2'd2,
      EV_SLIDE = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_DOWN  = 2'd1,
      MODE_PRESS = 2'd2,
      MODE_SLIDE = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ELEC_NONE = 2'd0,
      ELEC_UP   = 2'd1,
      ELEC_DOWN = 2'd2
   } elec_type;

   typedef enum logic [1:0] {
      HOLD_NONE  = 2'd0,
      HOLD_DOWN  = 2'd1,
      HOLD_PRESS = 2'd2
   } hold_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_EVAL = 2'd1,
      ST_DIV  = 2'd2,
      ST_POST = 2'd3
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

@@ sv/tsgd_lane.sv @@
// tsgd_lane: one electrode lane, touch compare against baseline plus noise margin
// and the hold counter update with down and press detection
// depends on tsgd_pkg
module tsgd_lane
   import tsgd_pkg::*;
#(
   parameter int MEASURE_WIDTH = 16,
   parameter int COUNT_WIDTH   = 8
) (
   input  logic [MEASURE_WIDTH-1:0] measure,
   input  logic [CFG_WIDTH-1:0]     baseline,
   input  logic [CFG_WIDTH-1:0]     noise_threshold,
   output logic                     touched,
   input  logic                     touched_q,
   input  logic [COUNT_WIDTH-1:0]   hold_cnt,
   input  logic [THR_WIDTH-1:0]     down_detect_count,
   input  logic [THR_WIDTH-1:0]     press_detect_count,
   output logic [COUNT_WIDTH-1:0]   hold_cnt_next,
   output hold_type                 hold_status
);

   localparam int SUM_W = CFG_WIDTH + 1;
   localparam int CMP_W = (COUNT_WIDTH > THR_WIDTH) ? COUNT_WIDTH : THR_WIDTH;

   logic [SUM_W-1:0]       limit;
   logic [SUM_W-1:0]       measure_x;
   logic [CMP_W-1:0]       cnt_x;
   logic [CMP_W-1:0]       down_x;
   logic [CMP_W-1:0]       press_x;
   logic [COUNT_WIDTH-1:0] cnt_inc;

   assign limit     = {1'b0, baseline} + {1'b0, noise_threshold};
   assign measure_x = SUM_W'(measure);
   assign touched   = measure_x > limit;

   assign cnt_x   = CMP_W'(hold_cnt);
   assign down_x  = CMP_W'(down_detect_count);
   assign press_x = CMP_W'(press_detect_count);
   assign cnt_inc = (hold_cnt != '1) ? hold_cnt + COUNT_WIDTH'(1) : hold_cnt;

   always_comb begin
      hold_cnt_next = '0;
      hold_status   = HOLD_NONE;
      if (touched_q) begin
         if (cnt_x == press_x) begin
            hold_status   = HOLD_PRESS;
            hold_cnt_next = (cnt_x > down_x) ? COUNT_WIDTH'(cnt_x - down_x) : '0;
         end else begin
            hold_cnt_next = cnt_inc;
            hold_status   = (CMP_W'(cnt_inc) == down_x) ? HOLD_DOWN : HOLD_NONE;
         end
      end
   end

endmodule

@@ sv/tsgd_div.sv @@
// tsgd_div: restoring divider, one quotient bit per cycle
// depends on tsgd_pkg
module tsgd_div
   import tsgd_pkg::*;
#(
   parameter int NUM_W = 16,
   parameter int DEN_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic [NUM_W-1:0] quot,
   output div_stat_type     stat
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] rem_ff,  rem_in;
   logic [NUM_W-1:0] quo_ff,  quo_in;
   logic [DEN_W-1:0] den_ff,  den_in;
   logic [CNT_W-1:0] cnt_ff,  cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   shifted;
   logic [DEN_W+1:0] sub;
   logic             ge;

   assign shifted = {rem_ff, quo_ff[NUM_W-1]};
   assign sub     = {1'b0, shifted} - {2'b00, den_ff};
   assign ge      = !sub[DEN_W+1];

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = numer;
         den_in  = denom;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? sub[DEN_W-1:0] : shifted[DEN_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quot      = quo_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

@@ sv/touch_slider_gesture_detector.sv @@
// touch_slider_gesture_detector: top level, two electrode lanes, merging slider
// machine and slide speed divider
// depends on tsgd_pkg, tsgd_lane, tsgd_div
//
// One scan is taken per transfer; both electrode lanes judge touch and update their
// hold counters side by side, and the slider machine merges them into one result.
// A scan runs from transfer to result through the steps transfer, evaluate and post;
// a slide whose hold count lies above the minimum adds the divide step for the restoring
// divider, which produces one quotient bit per cycle over a 16 bit dividend. One
// scan is worked at a time; the next scan is taken while the last result still waits.
module touch_slider_gesture_detector
   import tsgd_pkg::*;
#(
   parameter int MEASURE_WIDTH = 16,
   parameter int COUNT_WIDTH   = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [MEASURE_WIDTH-1:0] req_up_measure,
   input  logic [MEASURE_WIDTH-1:0] req_down_measure,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_event_kind,
   output logic                     rsp_detect_kind,
   output logic [SPEED_WIDTH-1:0]   rsp_slide_speed,
   output logic [1:0]               rsp_slider_mode,
   output logic                     rsp_up_touched,
   output logic                     rsp_down_touched,
   input  logic                     csr_we,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CFG_WIDTH-1:0]     csr_wdata
);

   localparam int CMP_W = (COUNT_WIDTH > THR_WIDTH) ? COUNT_WIDTH : THR_WIDTH;

   // configuration
   logic [CFG_WIDTH-1:0] noise_ff, base_up_ff, base_dn_ff;
   logic [THR_WIDTH-1:0] down_cnt_ff, press_cnt_ff, min_ff, max_ff, smax_ff;

   // slider state
   state_type              state_ff, state_in;
   mode_type               mode_ff;
   elec_type               last_ff;
   logic [COUNT_WIDTH-1:0] up_cnt_ff, dn_cnt_ff;
   logic [SPEED_WIDTH-1:0] speed_reg_ff;
   logic                   up_t_ff, dn_t_ff;
   event_type              pend_kind_ff, pend_kind_in;
   logic                   pend_detect_ff, pend_detect_in;

   // result register
   logic                   rsp_valid_ff;
   event_type              rsp_kind_ff;
   logic                   rsp_detect_ff;
   logic [SPEED_WIDTH-1:0] rsp_speed_ff;
   mode_type               rsp_mode_ff;
   logic                   rsp_up_ff, rsp_dn_ff;

   logic                   up_touch, dn_touch;
   logic [COUNT_WIDTH-1:0] up_cnt_next, dn_cnt_next;
   hold_type               up_status, dn_status;

   logic                   req_xfer, rsp_xfer, rsp_load, div_start;
   logic [COUNT_WIDTH-1:0] sel_cnt;
   logic [CMP_W-1:0]       sel_x;
   logic                   slide_ok, slide_div;
   logic [THR_WIDTH-1:0]   slide_diff, slide_den;
   logic [DIV_NUM_W-1:0]   slide_num, div_quot;
   div_stat_type           div_stat;
   elec_type               act_elec;

   tsgd_lane #(
      .MEASURE_WIDTH(MEASURE_WIDTH),
      .COUNT_WIDTH  (COUNT_WIDTH)
   ) u_lane_up (
      .measure           (req_up_measure),
      .baseline          (base_up_ff),
      .noise_threshold   (noise_ff),
      .touched           (up_touch),
      .touched_q         (up_t_ff),
      .hold_cnt          (up_cnt_ff),
      .down_detect_count (down_cnt_ff),
      .press_detect_count(press_cnt_ff),
      .hold_cnt_next     (up_cnt_next),
      .hold_status       (up_status)
   );

   tsgd_lane #(
      .MEASURE_WIDTH(MEASURE_WIDTH),
      .COUNT_WIDTH  (COUNT_WIDTH)
   ) u_lane_dn (
      .measure           (req_down_measure),
      .baseline          (base_dn_ff),
      .noise_threshold   (noise_ff),
      .touched           (dn_touch),
      .touched_q         (dn_t_ff),
      .hold_cnt          (dn_cnt_ff),
      .down_detect_count (down_cnt_ff),
      .press_detect_count(press_cnt_ff),
      .hold_cnt_next     (dn_cnt_next),
      .hold_status       (dn_status)
   );

   tsgd_div #(
      .NUM_W(DIV_NUM_W),
      .DEN_W(DIV_DEN_W)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .numer(slide_num),
      .denom(slide_den),
      .quot (div_quot),
      .stat (div_stat)
   );

   // slide decision from the last active electrode
   always_comb begin
      unique case (last_ff)
         ELEC_UP:   sel_cnt = up_cnt_ff;
         ELEC_DOWN: sel_cnt = dn_cnt_ff;
         default:   sel_cnt = '0;
      endcase
   end

   assign sel_x      = CMP_W'(sel_cnt);
   assign slide_ok   = (mode_ff == MODE_DOWN) && (sel_x < CMP_W'(max_ff));
   assign slide_div  = up_t_ff && dn_t_ff && slide_ok && (sel_x > CMP_W'(min_ff));
   assign slide_diff = THR_WIDTH'(sel_x - CMP_W'(min_ff));
   assign slide_den  = max_ff - min_ff;
   assign slide_num  = slide_diff * smax_ff;
   assign act_elec   = up_t_ff ? ELEC_UP : ELEC_DOWN;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid_ff && !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_EVAL;
         ST_EVAL: state_in = slide_div ? ST_DIV : ST_POST;
         ST_DIV:  if (div_stat.done) state_in = ST_POST;
         ST_POST: if (rsp_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // machine outputs
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      div_start = (state_ff == ST_EVAL) && slide_div;
      rsp_load  = (state_ff == ST_POST) && (!rsp_valid_ff || !rsp_stall);
   end

   // pending result of the evaluated scan
   always_comb begin
      pend_kind_in   = EV_NONE;
      pend_detect_in = 1'b0;
      if (up_t_ff && dn_t_ff) begin
         if (slide_ok) pend_kind_in = EV_SLIDE;
      end else if ((up_t_ff || dn_t_ff) && mode_ff != MODE_SLIDE &&
                   (act_elec == last_ff || mode_ff == MODE_IDLE)) begin
         if (dn_status != HOLD_NONE) begin
            pend_kind_in   = EV_DOWN;
            pend_detect_in = (dn_status == HOLD_PRESS);
         end else if (up_status != HOLD_NONE) begin
            pend_kind_in   = EV_UP;
            pend_detect_in = (up_status == HOLD_PRESS);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         noise_ff     <= RST_NOISE_THRESHOLD;
         base_up_ff   <= RST_BASELINE;
         base_dn_ff   <= RST_BASELINE;
         down_cnt_ff  <= RST_DOWN_DETECT_COUNT;
         press_cnt_ff <= RST_PRESS_DETECT_COUNT;
         min_ff       <= RST_SLIDE_COUNT_MIN;
         max_ff       <= RST_SLIDE_COUNT_MAX;
         smax_ff      <= RST_SLIDE_SPEED_MAX;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NOISE_THRESHOLD:    noise_ff     <= csr_wdata;
            CSR_BASELINE_UP:        base_up_ff   <= csr_wdata;
            CSR_BASELINE_DOWN:      base_dn_ff   <= csr_wdata;
            CSR_DOWN_DETECT_COUNT:  down_cnt_ff  <= csr_wdata[THR_WIDTH-1:0];
            CSR_PRESS_DETECT_COUNT: press_cnt_ff <= csr_wdata[THR_WIDTH-1:0];
            CSR_SLIDE_COUNT_MIN:    min_ff       <= csr_wdata[THR_WIDTH-1:0];
            CSR_SLIDE_COUNT_MAX:    max_ff       <= csr_wdata[THR_WIDTH-1:0];
            CSR_SLIDE_SPEED_MAX:    smax_ff      <= csr_wdata[THR_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // touch flags and pending result
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         up_t_ff <= up_touch;
         dn_t_ff <= dn_touch;
      end
      if (state_ff == ST_EVAL) begin
         pend_kind_ff   <= pend_kind_in;
         pend_detect_ff <= pend_detect_in;
      end
   end

   // slider machine state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_IDLE;
         last_ff      <= ELEC_NONE;
         up_cnt_ff    <= '0;
         dn_cnt_ff    <= '0;
         speed_reg_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_EVAL) begin
            if (up_t_ff && dn_t_ff) begin
               if (slide_ok) begin
                  mode_ff <= MODE_SLIDE;
                  if (!slide_div) speed_reg_ff <= '0;
               end
            end else if (!up_t_ff && !dn_t_ff) begin
               mode_ff   <= MODE_IDLE;
               last_ff   <= ELEC_NONE;
               up_cnt_ff <= '0;
               dn_cnt_ff <= '0;
            end else if (mode_ff != MODE_SLIDE &&
                         (act_elec == last_ff || mode_ff == MODE_IDLE)) begin
               last_ff   <= act_elec;
               up_cnt_ff <= up_cnt_next;
               dn_cnt_ff <= dn_cnt_next;
               if (dn_status != HOLD_NONE) begin
                  mode_ff <= (dn_status == HOLD_PRESS) ? MODE_PRESS : MODE_DOWN;
               end else if (up_status != HOLD_NONE) begin
                  mode_ff <= (up_status == HOLD_PRESS) ? MODE_PRESS : MODE_DOWN;
               end
            end
         end
         // quotient stays below the speed scale, so it fits eight bits
         if (state_ff == ST_DIV && div_stat.done) begin
            speed_reg_ff <= div_quot[SPEED_WIDTH-1:0];
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_xfer) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_kind_ff   <= pend_kind_ff;
         rsp_detect_ff <= pend_detect_ff;
         rsp_speed_ff  <= (pend_kind_ff == EV_SLIDE) ? speed_reg_ff : '0;
         rsp_mode_ff   <= mode_ff;
         rsp_up_ff     <= up_t_ff;
         rsp_dn_ff     <= dn_t_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_kind   = rsp_kind_ff;
   assign rsp_detect_kind  = rsp_detect_ff;
   assign rsp_slide_speed  = rsp_speed_ff;
   assign rsp_slider_mode  = rsp_mode_ff;
   assign rsp_up_touched   = rsp_up_ff;
   assign rsp_down_touched = rsp_dn_ff;

`ifndef SYNTH
   a_div_only_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> state_ff == ST_DIV)
      else $error("divider running outside the divide state");

   a_xfer_to_eval: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == ST_EVAL)
      else $error("accepted scan not evaluated");

   a_slide_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == EV_SLIDE |-> rsp_mode_ff == MODE_SLIDE)
      else $error("slide result without slide mode");

   a_speed_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff != EV_SLIDE |-> rsp_speed_ff == '0)
      else $error("speed reported without a slide");
`endif

endmodule
